[rtl/msal_pkg.sv]
// Package for the multi-slot array list engine: request and status codes,
// plus the item and command types shared by front, back and top level.
package msal_pkg;

   typedef enum logic [2:0] {
      REQ_CREATE = 3'd0,
      REQ_APPEND = 3'd1,
      REQ_POP    = 3'd2,
      REQ_DELETE = 3'd3,
      REQ_READ   = 3'd4
   } req_code_type;

   typedef enum logic [3:0] {
      ST_OK        = 4'd0,
      ST_BAD_SLOT  = 4'd1,
      ST_EXISTS    = 4'd2,
      ST_BAD_SIZE  = 4'd3,
      ST_NO_MEMORY = 4'd4,
      ST_NO_SLOT   = 4'd5,
      ST_FULL      = 4'd6,
      ST_EMPTY     = 4'd7,
      ST_NOT_FOUND = 4'd8
   } status_code_type;

   typedef struct packed {
      logic [2:0]         req_type;
      logic [3:0]         slot_number;
      logic [7:0]         size_request;
      logic signed [31:0] item_value;
   } req_item_type;

   typedef struct packed {
      logic [3:0]         status;
      logic               has_data;
      logic signed [31:0] data_value;
      logic               last;
   } rsp_item_type;

   // Back-end operations issued by the front end
   typedef enum logic [1:0] {
      OP_STATUS = 2'd0,
      OP_APPEND = 2'd1,
      OP_DELETE = 2'd2,
      OP_READ   = 2'd3
   } op_code_type;

endpackage

[rtl/msal_if.sv]
// Valid/ready channel interface carrying one item of payload type.
// Depends on nothing; payload width is a parameter.
interface msal_if #(
   parameter int W = 8
) (
   input logic clock
);
   logic         valid;
   logic         ready;
   logic [W-1:0] payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[rtl/msal_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
module msal_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

[rtl/msal_front.sv]
// Front end: accepts requests, checks them against slot bookkeeping, updates
// counts and issues back-end commands. Uses msal_pkg.
module msal_front #(
   parameter int NUM_SLOTS  = 10,
   parameter int SLOT_DEPTH = 16,
   parameter int SW         = 4,
   parameter int CW         = 5
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  msal_pkg::req_item_type    req_item,
   output logic                      cmd_valid,
   input  logic                      cmd_ready,
   output msal_pkg::op_code_type     cmd_op,
   output logic [3:0]                cmd_status,
   output logic [SW-1:0]             cmd_slot,
   output logic [CW-1:0]             cmd_count,
   output logic signed [31:0]        cmd_value,
   input  logic                      del_done,
   input  logic                      del_found,
   input  logic [SW-1:0]             del_slot
);
   logic [NUM_SLOTS-1:0] exists_ff;
   logic [CW-1:0]        cap_ff [NUM_SLOTS];
   logic [CW-1:0]        cnt_ff [NUM_SLOTS];
   logic                 busy_ff;

   logic                 slot_ok;
   logic [SW-1:0]        s;
   logic [CW-1:0]        n;
   logic [CW-1:0]        cap;
   logic                 known;
   logic                 take;
   logic                 is_delete;
   msal_pkg::op_code_type op;
   logic [3:0]           st;

   // Front accepts when the command slot is free and no delete is pending
   assign req_ready = cmd_ready && !busy_ff;
   assign take      = req_valid && req_ready;
   assign slot_ok   = (req_item.slot_number >= 4'd1) &&
                      ({28'd0, req_item.slot_number} <= 32'(NUM_SLOTS));
   assign s   = slot_ok ? SW'(req_item.slot_number - 4'd1) : '0;
   assign n   = cnt_ff[s];
   assign cap = cap_ff[s];
   assign known = (req_item.req_type <= msal_pkg::REQ_READ);

   // Classify the request
   always_comb begin
      op        = msal_pkg::OP_STATUS;
      st        = msal_pkg::ST_OK;
      is_delete = 1'b0;
      if (!slot_ok) begin
         st = msal_pkg::ST_BAD_SLOT;
      end else if (req_item.req_type == msal_pkg::REQ_CREATE) begin
         if (exists_ff[s]) begin
            st = msal_pkg::ST_EXISTS;
         end else if (req_item.size_request == 8'd0) begin
            st = msal_pkg::ST_BAD_SIZE;
         end else if ({24'd0, req_item.size_request} > 32'(SLOT_DEPTH)) begin
            st = msal_pkg::ST_NO_MEMORY;
         end
      end else if (!exists_ff[s]) begin
         st = msal_pkg::ST_NO_SLOT;
      end else begin
         case (req_item.req_type)
            msal_pkg::REQ_APPEND: begin
               if (n < cap) begin
                  op = msal_pkg::OP_APPEND;
               end else begin
                  st = msal_pkg::ST_FULL;
               end
            end
            msal_pkg::REQ_POP: begin
               if (n == '0) st = msal_pkg::ST_EMPTY;
            end
            msal_pkg::REQ_DELETE: begin
               if (n == '0) begin
                  st = msal_pkg::ST_EMPTY;
               end else begin
                  op        = msal_pkg::OP_DELETE;
                  is_delete = 1'b1;
               end
            end
            default: begin
               op = msal_pkg::OP_READ;
            end
         endcase
      end
   end

   // Hold bookkeeping and the command register
   always_ff @(posedge clock) begin
      if (reset) begin
         exists_ff <= '0;
         busy_ff   <= 1'b0;
         cmd_valid <= 1'b0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            cap_ff[i] <= '0;
            cnt_ff[i] <= '0;
         end
      end else begin
         if (take && known) begin
            cmd_valid <= 1'b1;
         end else if (cmd_valid && cmd_ready) begin
            cmd_valid <= 1'b0;
         end
         if (del_done) begin
            busy_ff <= 1'b0;
            if (del_found) cnt_ff[del_slot] <= cnt_ff[del_slot] - CW'(1);
         end
         if (take && known) begin
            cmd_op     <= op;
            cmd_status <= st;
            cmd_slot   <= s;
            cmd_count  <= n;
            cmd_value  <= req_item.item_value;
            if (is_delete) busy_ff <= 1'b1;
            if (slot_ok && st == msal_pkg::ST_OK) begin
               case (req_item.req_type)
                  msal_pkg::REQ_CREATE: begin
                     exists_ff[s] <= 1'b1;
                     cap_ff[s]    <= CW'(req_item.size_request);
                     cnt_ff[s]    <= '0;
                  end
                  msal_pkg::REQ_APPEND: cnt_ff[s] <= n + CW'(1);
                  msal_pkg::REQ_POP:    cnt_ff[s] <= n - CW'(1);
                  default: ;
               endcase
            end
         end
      end
   end
endmodule

[rtl/msal_back.sv]
// Back end: executes append, delete (search then shift) and read streaming
// against the value RAM. Uses msal_pkg and msal_ram.
module msal_back #(
   parameter int NUM_SLOTS  = 10,
   parameter int SLOT_DEPTH = 16,
   parameter int SW         = 4,
   parameter int CW         = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_valid,
   output logic                  cmd_ready,
   input  msal_pkg::op_code_type cmd_op,
   input  logic [3:0]            cmd_status,
   input  logic [SW-1:0]         cmd_slot,
   input  logic [CW-1:0]         cmd_count,
   input  logic signed [31:0]    cmd_value,
   output logic                  del_done,
   output logic                  del_found,
   output logic [SW-1:0]         del_slot,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output msal_pkg::rsp_item_type rsp_item
);
   localparam int DEPTH = NUM_SLOTS * SLOT_DEPTH;
   localparam int MW    = $clog2(DEPTH);

   typedef enum logic [2:0] {
      S_IDLE, S_EMIT, S_SRCH, S_SHIFT, S_READ
   } state_type;

   state_type           state_ff;
   logic [SW-1:0]       slot_ff;
   logic [CW-1:0]       n_ff;
   logic [CW-1:0]       idx_ff;
   logic                found_ff;
   logic                wait_ff;
   logic signed [31:0]  value_ff;
   logic                wr_en;
   logic [MW-1:0]       wr_addr;
   logic [31:0]         wr_data;
   logic [MW-1:0]       rd_addr;
   logic [31:0]         rd_data;
   logic [MW-1:0]       base;
   logic                out_free;
   logic                rsp_load;

   assign base     = MW'(slot_ff) * MW'(SLOT_DEPTH);
   assign out_free = !rsp_valid || rsp_ready;
   assign cmd_ready = (state_ff == S_IDLE) && out_free;

   msal_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // RAM address and write control
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = base + MW'(idx_ff);
      wr_data = rd_data;
      rd_addr = base + MW'(idx_ff);
      if (state_ff == S_IDLE) begin
         wr_en   = cmd_valid && cmd_ready && cmd_op == msal_pkg::OP_APPEND;
         wr_addr = MW'(cmd_slot) * MW'(SLOT_DEPTH) + MW'(cmd_count);
         wr_data = cmd_value;
         rd_addr = MW'(cmd_slot) * MW'(SLOT_DEPTH);
      end else if (state_ff == S_SHIFT) begin
         // read idx, then write the registered read data to idx-1
         wr_en   = !wait_ff;
         wr_addr = base + MW'(idx_ff) - MW'(1);
      end
   end

   // Load the output register when a result item is ready
   always_comb begin
      case (state_ff)
         S_IDLE: rsp_load = cmd_valid && cmd_ready &&
                            cmd_op != msal_pkg::OP_DELETE &&
                            !(cmd_op == msal_pkg::OP_READ && cmd_count != '0);
         S_EMIT: rsp_load = out_free;
         S_READ: rsp_load = !wait_ff && out_free;
         default: rsp_load = 1'b0;
      endcase
   end

   // Sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rsp_valid <= 1'b0;
         del_done  <= 1'b0;
      end else begin
         del_done <= (state_ff == S_EMIT) && out_free;
         if (rsp_load) begin
            rsp_valid <= 1'b1;
         end else if (rsp_valid && rsp_ready) begin
            rsp_valid <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (cmd_valid && cmd_ready) begin
                  slot_ff  <= cmd_slot;
                  n_ff     <= cmd_count;
                  value_ff <= cmd_value;
                  idx_ff   <= '0;
                  wait_ff  <= 1'b1;
                  found_ff <= 1'b0;
                  case (cmd_op)
                     msal_pkg::OP_DELETE: state_ff <= S_SRCH;
                     msal_pkg::OP_READ: begin
                        if (cmd_count == '0) begin
                           rsp_item  <= '{msal_pkg::ST_OK, 1'b0, 32'sd0, 1'b1};
                        end else begin
                           state_ff <= S_READ;
                        end
                     end
                     default: begin
                        rsp_item  <= '{cmd_status, 1'b0, 32'sd0, 1'b1};
                     end
                  endcase
               end
            end
            S_SRCH: begin
               // rd_data holds entry idx
               if (wait_ff) begin
                  wait_ff <= 1'b0;
               end else if ($signed(rd_data) == value_ff) begin
                  found_ff <= 1'b1;
                  state_ff <= S_SHIFT;
                  idx_ff   <= idx_ff + CW'(1);
                  wait_ff  <= 1'b1;
               end else if (idx_ff + CW'(1) == n_ff) begin
                  state_ff <= S_EMIT;
               end else begin
                  idx_ff  <= idx_ff + CW'(1);
                  wait_ff <= 1'b1;
               end
            end
            S_SHIFT: begin
               // idx points at the entry after the current hole
               if (idx_ff >= n_ff) begin
                  state_ff <= S_EMIT;
               end else if (wait_ff) begin
                  wait_ff <= 1'b0;
               end else begin
                  idx_ff  <= idx_ff + CW'(1);
                  wait_ff <= 1'b1;
               end
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_item  <= '{found_ff ? msal_pkg::ST_OK : msal_pkg::ST_NOT_FOUND,
                                 1'b0, 32'sd0, 1'b1};
                  state_ff  <= S_IDLE;
               end
            end
            S_READ: begin
               if (wait_ff) begin
                  wait_ff <= 1'b0;
               end else if (out_free) begin
                  rsp_item  <= '{msal_pkg::ST_OK, 1'b1, $signed(rd_data),
                                 idx_ff + CW'(1) == n_ff};
                  idx_ff    <= idx_ff + CW'(1);
                  wait_ff   <= 1'b1;
                  if (idx_ff + CW'(1) == n_ff) state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign del_found = found_ff;
   assign del_slot  = slot_ff;
endmodule

[rtl/multi_slot_array_list_engine.sv]
// Multi-slot array list engine. Create, append, pop and every error answer
// in the cycle after the back end takes the command, so with an idle back end
// and a free result channel one such item is taken per cycle. Delete-value
// searches the slot entry by entry and then shifts the later entries down
// one place, each step waiting on a read of the single-read-port value RAM,
// and the front end holds off new items until it is done. Read streams the
// elements one RAM read at a time, and the back end takes no new command
// until the stream ends. The front end checks requests and keeps slot
// counts; the back end runs RAM sequences; one command register joins them.
module multi_slot_array_list_engine #(
   parameter int NUM_SLOTS  = 10,
   parameter int SLOT_DEPTH = 16
) (
   input logic  clock,
   input logic  reset,
   msal_if.sink   req,
   msal_if.source rsp
);
   localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CW = $clog2(SLOT_DEPTH + 1);

   logic                  cmd_valid;
   logic                  cmd_ready;
   msal_pkg::op_code_type cmd_op;
   logic [3:0]            cmd_status;
   logic [SW-1:0]         cmd_slot;
   logic [CW-1:0]         cmd_count;
   logic signed [31:0]    cmd_value;
   logic                  del_done;
   logic                  del_found;
   logic [SW-1:0]         del_slot;
   msal_pkg::rsp_item_type rsp_item;

   msal_front #(.NUM_SLOTS(NUM_SLOTS), .SLOT_DEPTH(SLOT_DEPTH),
                .SW(SW), .CW(CW)) u_front (
      .clock, .reset,
      .req_valid  (req.valid),
      .req_ready  (req.ready),
      .req_item   (msal_pkg::req_item_type'(req.payload)),
      .cmd_valid, .cmd_ready, .cmd_op, .cmd_status, .cmd_slot,
      .cmd_count, .cmd_value, .del_done, .del_found, .del_slot
   );

   msal_back #(.NUM_SLOTS(NUM_SLOTS), .SLOT_DEPTH(SLOT_DEPTH),
               .SW(SW), .CW(CW)) u_back (
      .clock, .reset,
      .cmd_valid, .cmd_ready, .cmd_op, .cmd_status, .cmd_slot,
      .cmd_count, .cmd_value, .del_done, .del_found, .del_slot,
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .rsp_item  (rsp_item)
   );

   assign rsp.payload = rsp_item;
endmodule
